// ===== hdl/hrt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrt_pkg
// Shared types and constants of the hashed result table.
// ----------------------------------------------------------------------------
package hrt_pkg;

  localparam int INDEX_BITS_DEF = 16;

  localparam int KEY_W   = 64;
  localparam int SCORE_W = 31;
  localparam int FSC_W   = 33;
  localparam int DEPTH_W = 8;
  localparam int FLAG_W  = 2;
  localparam int SQ_W    = 6;
  localparam int CODE_W  = 3;
  localparam int WORD_W  = 64;
  localparam int CFG_W   = 8;
  localparam int ITEM_W  = 128;
  localparam int RES_W   = 64;

  localparam logic KIND_PROBE = 1'b0;
  localparam logic KIND_STORE = 1'b1;

  localparam logic [SCORE_W-1:0] SCORE_BIAS   = 31'h4000_0000;
  localparam logic [FSC_W-1:0]   SCORE_OFFSET = 33'h0_4000_0000;

  typedef struct packed {
    logic                 kind;
    logic [KEY_W-1:0]     key;
    logic [SCORE_W-1:0]   score;
    logic [DEPTH_W-1:0]   depth;
    logic [FLAG_W-1:0]    flag;
    logic [SQ_W-1:0]      from_sq;
    logic [SQ_W-1:0]      to_sq;
    logic [CODE_W-1:0]    promo;
    logic [CODE_W-1:0]    mkind;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] check;
    logic [WORD_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic               hit;
    logic               written;
    logic [FSC_W-1:0]   score;
    logic [DEPTH_W-1:0] depth;
    logic [FLAG_W-1:0]  flag;
    logic [SQ_W-1:0]    from_sq;
    logic [SQ_W-1:0]    to_sq;
    logic [CODE_W-1:0]  promo;
    logic [CODE_W-1:0]  mkind;
  } rslt_t;

endpackage
`default_nettype wire

// ===== hdl/hrt_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrt_mem
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hrt_mem #(
  parameter int INDEX_BITS = hrt_pkg::INDEX_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [INDEX_BITS-1:0] wr_addr,
  input  wire hrt_pkg::entry_t       wr_data,
  input  wire logic                  rd_en,
  input  wire logic [INDEX_BITS-1:0] rd_addr,
  output hrt_pkg::entry_t            rd_data
);

  localparam int DEPTH = 1 << INDEX_BITS;

  hrt_pkg::entry_t mem_r [DEPTH];
  hrt_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== hdl/hrt_lookup.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrt_lookup
// Signature check, replacement decision, entry packing and result unpacking.
// ----------------------------------------------------------------------------
module hrt_lookup (
  input  wire hrt_pkg::req_t                  req,
  input  wire hrt_pkg::entry_t                entry,
  input  wire logic [hrt_pkg::FLAG_W-1:0]     exact_code,
  output logic                                wr,
  output hrt_pkg::entry_t                     wr_entry,
  output hrt_pkg::rslt_t                      rslt
);

  logic                          match;
  logic                          is_store;
  logic                          keep;
  logic [hrt_pkg::DEPTH_W-1:0]   old_depth;
  logic [hrt_pkg::FLAG_W-1:0]    old_flag;
  logic [hrt_pkg::WORD_W-1:0]    new_word;

  assign old_depth = entry.data[39:32];
  assign old_flag  = entry.data[41:40];
  assign match     = (entry.check ^ entry.data) == req.key;
  assign is_store  = req.kind == hrt_pkg::KIND_STORE;
  assign keep      = match && (old_depth > req.depth) && (old_flag == exact_code);
  assign wr        = is_store && !keep;

  assign new_word = {4'b0, req.mkind, req.promo, req.to_sq, req.from_sq, req.flag,
                     req.depth, 1'b0, req.score ^ hrt_pkg::SCORE_BIAS};

  assign wr_entry.data  = new_word;
  assign wr_entry.check = req.key ^ new_word;

  always_comb begin
    rslt         = '0;
    rslt.written = wr;
    if (!is_store && match) begin
      rslt.hit     = 1'b1;
      rslt.score   = {1'b0, entry.data[31:0]} - hrt_pkg::SCORE_OFFSET;
      rslt.depth   = old_depth;
      rslt.flag    = old_flag;
      rslt.from_sq = entry.data[47:42];
      rslt.to_sq   = entry.data[53:48];
      rslt.promo   = entry.data[56:54];
      rslt.mkind   = entry.data[59:57];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/hashed_result_table.sv =====
`default_nettype none
// Throughput: one item per cycle unless out_tready stalls; each item is one
//   read-modify-write of its entry, and a write forwarded to the next item's
//   read keeps neighbors apart. Items pass stage 1, then the output register.
// Reset: clears exact_flag_code and runs a clearing pass over all 2^INDEX_BITS
//   entries of the entry memory; in_tready stays low until it ends.
// ----------------------------------------------------------------------------
// hashed_result_table
// Direct-mapped table of search results with XOR check word and
// depth-preferred replacement of exact entries.
// ----------------------------------------------------------------------------
module hashed_result_table #(
  parameter int INDEX_BITS = hrt_pkg::INDEX_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // cfg: [1:0] exact_flag_code, rest zero
  input  wire logic                        cfg_tvalid,
  output logic                             cfg_tready,
  input  wire logic [hrt_pkg::CFG_W-1:0]   cfg_tdata,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // in_tdata: key, score, search_depth, entry_flag, move_from, move_to,
  //           move_promo, move_kind, zero pad
  input  wire logic [hrt_pkg::ITEM_W-1:0]  in_tdata,
  // in_tuser: kind
  input  wire logic                        in_tuser,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // out_tdata: found_score, found_depth, found_flag, found_from, found_to,
  //            found_promo, found_move_kind, zero pad
  output logic [hrt_pkg::RES_W-1:0]        out_tdata,
  // out_tuser: hit, written
  output logic [1:0]                       out_tuser
);

  logic [hrt_pkg::FLAG_W-1:0] exact_r;

  logic                  clr_busy_r;
  logic [INDEX_BITS-1:0] clr_idx_r;

  hrt_pkg::req_t   in_req;
  logic            in_acc;

  logic            s1_valid_r;
  hrt_pkg::req_t   s1_req_r;
  logic            s1_adv;
  logic [INDEX_BITS-1:0] s1_idx;

  logic            byp_r;
  hrt_pkg::entry_t byp_entry_r;
  hrt_pkg::entry_t mem_rdata;
  hrt_pkg::entry_t cur_entry;

  logic            lk_wr;
  hrt_pkg::entry_t lk_entry;
  hrt_pkg::rslt_t  lk_rslt;

  logic            out_valid_r;
  hrt_pkg::rslt_t  out_rslt_r;

  logic                  mem_wr;
  logic [INDEX_BITS-1:0] mem_waddr;
  hrt_pkg::entry_t       mem_wdata;

  assign in_req.kind    = in_tuser;
  assign in_req.key     = in_tdata[63:0];
  assign in_req.score   = in_tdata[94:64];
  assign in_req.depth   = in_tdata[102:95];
  assign in_req.flag    = in_tdata[104:103];
  assign in_req.from_sq = in_tdata[110:105];
  assign in_req.to_sq   = in_tdata[116:111];
  assign in_req.promo   = in_tdata[119:117];
  assign in_req.mkind   = in_tdata[122:120];

  // config
  assign cfg_tready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exact_r <= '0;
    end else if (cfg_tvalid) begin
      exact_r <= cfg_tdata[hrt_pkg::FLAG_W-1:0];
    end
  end

  // clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == '1) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // pipeline control
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clr_busy_r && (!s1_valid_r || s1_adv);
  assign in_acc    = in_tvalid && in_tready;
  assign s1_idx    = s1_req_r.key[INDEX_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      byp_r      <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        byp_r      <= s1_adv && lk_wr && (s1_idx == in_req.key[INDEX_BITS-1:0]);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
        byp_r      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r    <= in_req;
      byp_entry_r <= lk_entry;
    end
  end

  hrt_mem #(
    .INDEX_BITS(INDEX_BITS)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_en  (in_acc),
    .rd_addr(in_req.key[INDEX_BITS-1:0]),
    .rd_data(mem_rdata)
  );

  assign cur_entry = byp_r ? byp_entry_r : mem_rdata;

  hrt_lookup u_lookup (
    .req       (s1_req_r),
    .entry     (cur_entry),
    .exact_code(exact_r),
    .wr        (lk_wr),
    .wr_entry  (lk_entry),
    .rslt      (lk_rslt)
  );

  assign mem_wr    = clr_busy_r || (s1_adv && lk_wr);
  assign mem_waddr = clr_busy_r ? clr_idx_r : s1_idx;
  assign mem_wdata = clr_busy_r ? '0 : lk_entry;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_rslt_r <= lk_rslt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b0, out_rslt_r.mkind, out_rslt_r.promo, out_rslt_r.to_sq,
                       out_rslt_r.from_sq, out_rslt_r.flag, out_rslt_r.depth,
                       out_rslt_r.score};
  assign out_tuser  = {out_rslt_r.written, out_rslt_r.hit};

  // checks
  a_no_item_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!in_tready && !s1_valid_r))
    else $error("item taken during clearing pass");

  a_byp_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    byp_r |-> s1_valid_r)
    else $error("forwarding flag without item in stage");

  a_write_only_store: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && lk_wr) |-> (s1_req_r.kind == hrt_pkg::KIND_STORE))
    else $error("probe would write the table");

  a_acc_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted item lost before lookup");

endmodule
`default_nettype wire
